@@ src/pngu_pkg.sv @@
package pngu_pkg;

   // Line buffer geometry
   localparam int MAX_ROW_BYTES = 16384;
   localparam int COL_W = $clog2(MAX_ROW_BYTES);
   localparam int POS_W = $clog2(MAX_ROW_BYTES + 1);
   localparam int BPP_W = 3;
   localparam int RB_W = 15;
   localparam int CMP_W = (POS_W > RB_W) ? POS_W : RB_W;
   localparam int CSR_W = RB_W;

   // Work queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Largest pixel width in bytes
   localparam int MAX_BPP = 4;
   localparam int SEL_W = $clog2(MAX_BPP);

   // Register indexes
   typedef enum logic [0:0] {
      CSR_BYTES_PER_PIXEL = 1'b0,
      CSR_ROW_BYTES       = 1'b1
   } csr_index_type;

   // Row filter codes
   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_image;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       row_end;
      logic       bad_filter;
   } rsp_type;

   // One classified byte of work for the back end
   typedef struct packed {
      logic [7:0]       data_byte;
      filter_type       filter;
      logic [COL_W-1:0] col;
      logic [SEL_W-1:0] sel;
      logic             has_left;
      logic             first_row;
      logic             last;
      logic             bad;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

@@ src/png_scanline_unfilter_core.sv @@
// An accepted data byte passes through the work queue, the stage (line buffer read)
// and the output register before it is presented on rsp; rsp stalls hold it back.
// Throughput: one byte per cycle while rsp is not stalled; the registered left-byte
// feedback through predictor and adder sets it; legal filter bytes give no response.
// Reset (synchronous, active high) restores the register defaults and empties the
// queue and stages; the line buffer is not cleared and needs no clearing pass.
module png_scanline_unfilter_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  pngu_pkg::csr_index_type      csr_index,
   input  logic [pngu_pkg::CSR_W-1:0]   csr_wdata,
   input  logic                         req_valid,
   input  pngu_pkg::req_type            req_data,
   output logic                         req_stall,
   output logic                         rsp_valid,
   output pngu_pkg::rsp_type            rsp_data,
   input  logic                         rsp_stall
);

   logic [pngu_pkg::BPP_W-1:0] bpp_ff;
   logic [pngu_pkg::RB_W-1:0]  row_bytes_ff;
   pngu_pkg::push_type         push;
   pngu_pkg::entry_type        head;
   pngu_pkg::q_status_type     q_status;
   logic                       pop;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= pngu_pkg::BPP_W'(4);
         row_bytes_ff <= pngu_pkg::RB_W'(16384);
      end else if (csr_write_en) begin
         case (csr_index)
            pngu_pkg::CSR_BYTES_PER_PIXEL: bpp_ff <= csr_wdata[pngu_pkg::BPP_W-1:0];
            pngu_pkg::CSR_ROW_BYTES:       row_bytes_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   pngu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .bpp_cfg       (bpp_ff),
      .row_bytes_cfg (row_bytes_ff),
      .req_valid     (req_valid),
      .req_data      (req_data),
      .req_stall     (req_stall),
      .q_status      (q_status),
      .push          (push)
   );

   pngu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   pngu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // Checks
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty at once");

   a_filter_no_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.new_image &&
       req_data.data_byte <= 8'(pngu_pkg::FILT_PAETH)) |-> !push.valid)
      else $error("legal filter byte queued as work");

   a_bad_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bad_filter) |->
      (rsp_data.pixel_byte == 8'h00 && !rsp_data.row_end))
      else $error("error response carries data");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

@@ src/pngu_front.sv @@
module pngu_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [pngu_pkg::BPP_W-1:0]   bpp_cfg,
   input  logic [pngu_pkg::RB_W-1:0]    row_bytes_cfg,
   input  logic                         req_valid,
   input  pngu_pkg::req_type            req_data,
   output logic                         req_stall,
   input  pngu_pkg::q_status_type       q_status,
   output pngu_pkg::push_type           push
);

   logic [pngu_pkg::POS_W-1:0] pos_ff, pos_in;
   pngu_pkg::filter_type       filter_ff, filter_in;
   logic                       first_ff, first_in;
   logic                       err_ff, err_in;

   logic                       fire;
   logic [pngu_pkg::POS_W-1:0] pos_cur;
   logic                       first_cur;
   logic                       err_cur;
   logic [pngu_pkg::BPP_W-1:0] bpp_eff;
   logic [pngu_pkg::RB_W-1:0]  rb_eff;
   logic [pngu_pkg::COL_W-1:0] col;
   logic                       last;

   assign req_stall = q_status.full;
   assign fire = req_valid && !q_status.full;

   // Clamp the registers to their legal ranges
   always_comb begin
      bpp_eff = bpp_cfg;
      if (bpp_cfg == '0) begin
         bpp_eff = pngu_pkg::BPP_W'(1);
      end else if (bpp_cfg > pngu_pkg::BPP_W'(pngu_pkg::MAX_BPP)) begin
         bpp_eff = pngu_pkg::BPP_W'(pngu_pkg::MAX_BPP);
      end
      rb_eff = row_bytes_cfg;
      if (row_bytes_cfg == '0) begin
         rb_eff = pngu_pkg::RB_W'(1);
      end else if (pngu_pkg::CMP_W'(row_bytes_cfg) >
                   pngu_pkg::CMP_W'(pngu_pkg::MAX_ROW_BYTES)) begin
         rb_eff = pngu_pkg::RB_W'(pngu_pkg::MAX_ROW_BYTES);
      end
   end

   // new_image restarts the image before the byte is classified
   assign pos_cur   = req_data.new_image ? '0 : pos_ff;
   assign first_cur = req_data.new_image ? 1'b1 : first_ff;
   assign err_cur   = req_data.new_image ? 1'b0 : err_ff;

   assign col  = pngu_pkg::COL_W'(pos_cur - pngu_pkg::POS_W'(1));
   assign last = (pngu_pkg::CMP_W'(col) + pngu_pkg::CMP_W'(1)) >= pngu_pkg::CMP_W'(rb_eff);

   // Classify the request
   always_comb begin
      pos_in    = pos_ff;
      filter_in = filter_ff;
      first_in  = first_ff;
      err_in    = err_ff;
      push.valid           = 1'b0;
      push.entry.data_byte = req_data.data_byte;
      push.entry.filter    = filter_ff;
      push.entry.col       = col;
      push.entry.sel       = pngu_pkg::SEL_W'(bpp_eff - pngu_pkg::BPP_W'(1));
      push.entry.has_left  = pngu_pkg::CMP_W'(col) >= pngu_pkg::CMP_W'(bpp_eff);
      push.entry.first_row = first_cur;
      push.entry.last      = last;
      push.entry.bad       = 1'b0;
      if (fire) begin
         pos_in   = pos_cur;
         first_in = first_cur;
         err_in   = err_cur;
         if (err_cur) begin
            // dropped until the next image
         end else if (pos_cur == '0) begin
            if (req_data.data_byte > 8'(pngu_pkg::FILT_PAETH)) begin
               err_in          = 1'b1;
               push.valid      = 1'b1;
               push.entry.bad  = 1'b1;
            end else begin
               filter_in = pngu_pkg::filter_type'(req_data.data_byte[2:0]);
               pos_in    = pngu_pkg::POS_W'(1);
            end
         end else begin
            push.valid = 1'b1;
            if (last) begin
               pos_in   = '0;
               first_in = 1'b0;
            end else begin
               pos_in = pngu_pkg::POS_W'(col) + pngu_pkg::POS_W'(2);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         filter_ff <= pngu_pkg::FILT_NONE;
         first_ff  <= 1'b1;
         err_ff    <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         filter_ff <= filter_in;
         first_ff  <= first_in;
         err_ff    <= err_in;
      end
   end

endmodule

@@ src/pngu_queue.sv @@
module pngu_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  pngu_pkg::push_type      push,
   input  logic                    pop,
   output pngu_pkg::entry_type     head,
   output pngu_pkg::q_status_type  q_status
);

   pngu_pkg::entry_type         slots_ff [pngu_pkg::QUEUE_DEPTH];
   logic [pngu_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pngu_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pngu_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign q_status.full  = count_ff == pngu_pkg::QCNT_W'(pngu_pkg::QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;
   assign do_push = push.valid && !q_status.full;
   assign do_pop  = pop && !q_status.empty;
   assign head    = slots_ff[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + pngu_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + pngu_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + pngu_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - pngu_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

@@ src/pngu_back.sv @@
module pngu_back (
   input  logic                    clock,
   input  logic                    reset,
   input  pngu_pkg::entry_type     head,
   input  pngu_pkg::q_status_type  q_status,
   output logic                    pop,
   output logic                    rsp_valid,
   output pngu_pkg::rsp_type       rsp_data,
   input  logic                    rsp_stall
);

   // Previous row line buffer
   logic [7:0] prior_row [pngu_pkg::MAX_ROW_BYTES];

   pngu_pkg::entry_type s1_ff;
   logic                s1_valid_ff, s1_valid_in;
   logic [7:0]          up_mem_ff;
   logic                byp_ff;
   logic [7:0]          byp_val_ff;
   logic [31:0]         left_win_ff, left_win_in;
   logic [31:0]         ul_win_ff, ul_win_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pngu_pkg::rsp_type   rsp_ff;

   logic       s1_fire;
   logic       wr_en;
   logic [4:0] shift;
   logic [7:0] left;
   logic [7:0] up;
   logic [7:0] ul;
   logic [8:0] avg_sum;
   logic [7:0] pred;
   logic [7:0] value;

   function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      logic signed [9:0] da_s;
      logic signed [9:0] db_s;
      logic signed [9:0] dc_s;
      logic [8:0]        da;
      logic [8:0]        db;
      logic [8:0]        dc;
      da_s = $signed({2'b00, b}) - $signed({2'b00, c});
      db_s = $signed({2'b00, a}) - $signed({2'b00, c});
      dc_s = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
      da = da_s[9] ? 9'(-da_s) : da_s[8:0];
      db = db_s[9] ? 9'(-db_s) : db_s[8:0];
      dc = dc_s[9] ? 9'(-dc_s) : dc_s[8:0];
      if (da <= db && da <= dc) begin
         return a;
      end else if (db <= dc) begin
         return b;
      end else begin
         return c;
      end
   endfunction

   // Stage advance
   assign s1_fire = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign pop     = !q_status.empty && (!s1_valid_ff || s1_fire);
   assign wr_en   = s1_fire && !s1_ff.bad;

   // Predictor operands
   assign shift = {s1_ff.sel, 3'b000};
   assign up    = s1_ff.first_row ? 8'h00 : (byp_ff ? byp_val_ff : up_mem_ff);
   assign left  = s1_ff.has_left ? left_win_ff[shift +: 8] : 8'h00;
   assign ul    = (s1_ff.has_left && !s1_ff.first_row) ? ul_win_ff[shift +: 8] : 8'h00;
   assign avg_sum = {1'b0, left} + {1'b0, up};

   always_comb begin
      case (s1_ff.filter)
         pngu_pkg::FILT_SUB:   pred = left;
         pngu_pkg::FILT_UP:    pred = up;
         pngu_pkg::FILT_AVG:   pred = avg_sum[8:1];
         pngu_pkg::FILT_PAETH: pred = paeth(left, up, ul);
         default:              pred = 8'h00;
      endcase
   end

   assign value = s1_ff.data_byte + pred;

   // Next state
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      left_win_in  = left_win_ff;
      ul_win_in    = ul_win_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
         s1_valid_in  = 1'b0;
      end
      if (pop) begin
         s1_valid_in = 1'b1;
      end
      if (wr_en) begin
         left_win_in = {left_win_ff[23:0], value};
         ul_win_in   = {ul_win_ff[23:0], up};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_win_ff  <= '0;
         ul_win_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         left_win_ff  <= left_win_in;
         ul_win_ff    <= ul_win_in;
      end
   end

   // Stage payload and line buffer read; a write to the same column bypasses
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ff      <= head;
         up_mem_ff  <= prior_row[head.col];
         byp_ff     <= wr_en && (s1_ff.col == head.col);
         byp_val_ff <= value;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prior_row[s1_ff.col] <= value;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_ff.pixel_byte <= s1_ff.bad ? 8'h00 : value;
         rsp_ff.row_end    <= s1_ff.bad ? 1'b0 : s1_ff.last;
         rsp_ff.bad_filter <= s1_ff.bad;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ sim/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 8;
   localparam int STUCK_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 80;
   localparam int PHASE_ITEMS   = 175;

   // DUT connections; the driven inputs are all known from time zero
   logic                       clock        = 1'b0;
   logic                       reset        = 1'b1;
   logic                       csr_write_en = 1'b0;
   pngu_pkg::csr_index_type    csr_index    = pngu_pkg::CSR_BYTES_PER_PIXEL;
   logic [pngu_pkg::CSR_W-1:0] csr_wdata    = '0;
   logic                       req_valid    = 1'b0;
   pngu_pkg::req_type          req_data     = '0;
   logic                       req_stall;
   logic                       rsp_valid;
   pngu_pkg::rsp_type          rsp_data;
   logic                       rsp_stall    = 1'b0;

   png_scanline_unfilter_core dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_data     (req_data),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .rsp_stall    (rsp_stall)
   );

   always #10 clock = ~clock;

   // Stimulus queue, expected pixels and bookkeeping
   pngu_pkg::req_type req_backlog[$];
   pngu_pkg::rsp_type pixel_due[$];
   pngu_pkg::rsp_type pixel_next;
   pngu_pkg::rsp_type pixel_want;
   int unsigned req_planned  = 0;
   int unsigned req_accepted = 0;
   int unsigned fail_count   = 0;
   int unsigned stuck_cycles = 0;
   bit          req_taken    = 1'b0;
   bit          tx_calm      = 1'b0;
   bit          rx_calm      = 1'b0;
   bit          hold_req     = 1'b0;
   int unsigned hold_left    = 0;
   int unsigned plan_rb      = 1;

   // Shadow of the unfilter state and registers
   logic [pngu_pkg::BPP_W-1:0] cfg_bpp = 3'd4;
   logic [pngu_pkg::RB_W-1:0]  cfg_rb  = 15'd16384;
   logic [7:0]                 prior_line [pngu_pkg::MAX_ROW_BYTES];
   logic [31:0]                left_bytes    = '0;
   logic [31:0]                upleft_bytes  = '0;
   int unsigned                row_pos       = 0;
   pngu_pkg::filter_type       cur_filter    = pngu_pkg::FILT_NONE;
   bit                         top_row       = 1'b1;
   bit                         filter_error  = 1'b0;

   task automatic report_mismatch(string what);
      if (fail_count < 50)
         $display("%0t mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   // Rebuilds one byte of the stream; returns 1 when it yields a response
   function automatic bit unfilter_byte(input pngu_pkg::req_type r,
                                        output pngu_pkg::rsp_type o);
      int unsigned bpp, rb, col, shift;
      logic [7:0]  left, up, ul, pred, val;
      logic [8:0]  sum;
      int          gap_a, gap_b, gap_c;
      bit          last;
      o = '0;
      if (r.new_image) begin
         row_pos      = 0;
         left_bytes   = '0;
         upleft_bytes = '0;
         top_row      = 1'b1;
         filter_error = 1'b0;
      end
      if (filter_error)
         return 1'b0;
      bpp = (cfg_bpp < 1) ? 1 :
            ((cfg_bpp > pngu_pkg::MAX_BPP) ? pngu_pkg::MAX_BPP : cfg_bpp);
      rb  = (cfg_rb < 1) ? 1 :
            ((cfg_rb > pngu_pkg::MAX_ROW_BYTES) ? pngu_pkg::MAX_ROW_BYTES : cfg_rb);

      // Filter byte opens the row
      if (row_pos == 0) begin
         if (r.data_byte > 8'(pngu_pkg::FILT_PAETH)) begin
            filter_error = 1'b1;
            o.bad_filter = 1'b1;
            return 1'b1;
         end
         cur_filter = pngu_pkg::filter_type'(r.data_byte[2:0]);
         row_pos    = 1;
         return 1'b0;
      end

      col = row_pos - 1;
      if (col >= pngu_pkg::MAX_ROW_BYTES)
         col = pngu_pkg::MAX_ROW_BYTES - 1;
      shift = 8 * (bpp - 1);
      left  = (col >= bpp) ? 8'(left_bytes >> shift) : 8'd0;
      up    = top_row ? 8'd0 : prior_line[col];
      ul    = (!top_row && col >= bpp) ? 8'(upleft_bytes >> shift) : 8'd0;

      case (cur_filter)
         pngu_pkg::FILT_SUB:   pred = left;
         pngu_pkg::FILT_UP:    pred = up;
         pngu_pkg::FILT_AVG: begin
            sum  = {1'b0, left} + {1'b0, up};
            pred = sum[8:1];
         end
         pngu_pkg::FILT_PAETH: begin
            gap_a = int'(up) - int'(ul);
            gap_b = int'(left) - int'(ul);
            gap_c = int'(left) + int'(up) - 2 * int'(ul);
            if (gap_a < 0) gap_a = -gap_a;
            if (gap_b < 0) gap_b = -gap_b;
            if (gap_c < 0) gap_c = -gap_c;
            if (gap_a <= gap_b && gap_a <= gap_c) pred = left;
            else if (gap_b <= gap_c) pred = up;
            else pred = ul;
         end
         default:    pred = 8'd0;
      endcase
      val = r.data_byte + pred;

      prior_line[col] = val;
      left_bytes      = {left_bytes[23:0], val};
      upleft_bytes    = {upleft_bytes[23:0], up};

      last = (col + 1 >= rb);
      if (last) begin
         row_pos      = 0;
         left_bytes   = '0;
         upleft_bytes = '0;
         top_row      = 1'b0;
      end else begin
         row_pos = col + 2;
      end
      o.pixel_byte = val;
      o.row_end    = last;
      return 1'b1;
   endfunction

   // Accept side: register shadow, prediction, response check, watchdog
   always @(posedge clock) begin
      if (reset) begin
         cfg_bpp      = 3'd4;
         cfg_rb       = 15'd16384;
         left_bytes   = '0;
         upleft_bytes = '0;
         row_pos      = 0;
         cur_filter   = pngu_pkg::FILT_NONE;
         top_row      = 1'b1;
         filter_error = 1'b0;
         req_taken    = 1'b0;
         stuck_cycles = 0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (csr_write_en) begin
            if (csr_index == pngu_pkg::CSR_BYTES_PER_PIXEL)
               cfg_bpp = csr_wdata[pngu_pkg::BPP_W-1:0];
            else cfg_rb = csr_wdata[pngu_pkg::RB_W-1:0];
         end
         if (req_taken) begin
            req_accepted++;
            if (unfilter_byte(req_data, pixel_next))
               pixel_due = {pixel_due, pixel_next};
         end
         if (rsp_valid && !rsp_stall) begin
            if (pixel_due.size() == 0) begin
               report_mismatch($sformatf("response %h with none due", rsp_data));
            end else begin
               pixel_want = pixel_due.pop_front();
               if (rsp_data.pixel_byte !== pixel_want.pixel_byte)
                  report_mismatch($sformatf("pixel_byte %h, want %h",
                                            rsp_data.pixel_byte, pixel_want.pixel_byte));
               if (rsp_data.row_end !== pixel_want.row_end)
                  report_mismatch($sformatf("row_end %b, want %b",
                                            rsp_data.row_end, pixel_want.row_end));
               if (rsp_data.bad_filter !== pixel_want.bad_filter)
                  report_mismatch($sformatf("bad_filter %b, want %b",
                                            rsp_data.bad_filter, pixel_want.bad_filter));
            end
         end
         if (req_taken || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
         else stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   // Request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_backlog.size() != 0 && (tx_calm || $urandom_range(99) >= 37)) begin
            req_data  <= req_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side stall, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !rx_calm && ($urandom_range(99) < 37);
         end
      end
   end

   task automatic put(logic [7:0] b, bit ni);
      pngu_pkg::req_type r;
      r.data_byte = b;
      r.new_image = ni;
      req_backlog = {req_backlog, r};
      req_planned++;
   endtask

   function automatic logic [7:0] pick_byte();
      int unsigned k;
      k = $urandom_range(9);
      if (k == 0) return 8'h00;
      if (k == 1) return 8'hff;
      return 8'($urandom_range(255));
   endfunction

   task automatic put_row(logic [7:0] filt, int unsigned n, bit ni);
      put(filt, ni);
      repeat (n) put(pick_byte(), 1'b0);
   endtask

   // Wait until the block has nothing left, then let it settle
   task automatic settle();
      @(negedge clock);
      while (req_accepted != req_planned || pixel_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(pngu_pkg::csr_index_type idx,
                            logic [pngu_pkg::CSR_W-1:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_geometry(logic [pngu_pkg::BPP_W-1:0] bpp,
                               logic [pngu_pkg::RB_W-1:0] rb);
      csr_write(pngu_pkg::CSR_BYTES_PER_PIXEL, {12'($urandom_range(4095)), bpp});
      csr_write(pngu_pkg::CSR_ROW_BYTES, rb);
      plan_rb = (rb == 0) ? 1 :
                ((rb > pngu_pkg::MAX_ROW_BYTES) ? pngu_pkg::MAX_ROW_BYTES : rb);
   endtask

   // One image: mostly whole rows, sometimes a bad filter or a cut-short row
   task automatic plan_image();
      int unsigned rows, k;
      rows = $urandom_range(1, 4);
      for (int unsigned r = 0; r < rows; r++) begin
         k = $urandom_range(99);
         if (k < 6) begin
            put(8'($urandom_range(5, 255)), r == 0);
            repeat ($urandom_range(3)) put(pick_byte(), 1'b0);
            return;
         end else if (k < 10) begin
            put_row(8'($urandom_range(4)), $urandom_range(plan_rb - 1), r == 0);
            return;
         end
         put_row(8'($urandom_range(4)), plan_rb, r == 0);
      end
   endtask

   logic [pngu_pkg::BPP_W-1:0] phase_bpp [10] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0,
                                                  3'd7, 3'd5, 3'd6, 3'd2, 3'd3};

   initial begin
      int unsigned start;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Every filter over a 3-byte row, one byte per pixel
      set_geometry(3'd1, 15'd3);
      put(8'(pngu_pkg::FILT_NONE), 1'b1);
      put(8'hff, 1'b0); put(8'h00, 1'b0); put(8'h80, 1'b0);
      put(8'(pngu_pkg::FILT_SUB), 1'b0);
      put(8'hff, 1'b0); put(8'h01, 1'b0); put(8'h7f, 1'b0);
      put(8'(pngu_pkg::FILT_UP), 1'b0);
      put(8'h01, 1'b0); put(8'hff, 1'b0); put(8'h80, 1'b0);
      put(8'(pngu_pkg::FILT_AVG), 1'b0);
      put(8'hff, 1'b0); put(8'hff, 1'b0); put(8'h01, 1'b0);
      put(8'(pngu_pkg::FILT_PAETH), 1'b0);
      put(8'h10, 1'b0); put(8'hf0, 1'b0); put(8'hff, 1'b0);
      // Bad filter, ignored bytes, bad filter on an image start
      put(8'd5, 1'b1); put(8'h00, 1'b0); put(8'h03, 1'b0);
      put(8'hff, 1'b1);
      settle();

      // Row length lowered in the middle of a row
      set_geometry(3'd1, 15'd6);
      put(8'(pngu_pkg::FILT_SUB), 1'b1);
      put(8'h20, 1'b0); put(8'h30, 1'b0); put(8'h40, 1'b0);
      settle();
      csr_write(pngu_pkg::CSR_ROW_BYTES, 15'd2);
      plan_rb = 2;
      put(8'h55, 1'b0);
      put_row(8'(pngu_pkg::FILT_UP), 2, 1'b0);
      settle();
      // Pixel width changed between rows, out of range values
      csr_write(pngu_pkg::CSR_BYTES_PER_PIXEL, {12'hfff, 3'd7});
      put_row(8'(pngu_pkg::FILT_PAETH), 2, 1'b0);
      settle();
      set_geometry(3'd0, 15'd0);
      put_row(8'(pngu_pkg::FILT_SUB), 1, 1'b1);
      put_row(8'(pngu_pkg::FILT_AVG), 1, 1'b0);
      put_row(8'(pngu_pkg::FILT_PAETH), 1, 1'b0);

      // Random phases over a spread of geometries
      for (int i = 0; i < 10; i++) begin
         settle();
         tx_calm = 1'b0;
         rx_calm = 1'b0;
         if (i == 0) set_geometry(phase_bpp[i], 15'd1);
         else if (i % 3 == 0) set_geometry(phase_bpp[i], 15'($urandom_range(1, 40)));
         else set_geometry(phase_bpp[i], 15'($urandom_range(2, 9)));
         if (i == 3) begin
            tx_calm = 1'b1;
            rx_calm = 1'b1;
         end
         start = req_planned;
         while (req_planned - start < PHASE_ITEMS) plan_image();
         if (i == 6) begin
            tx_calm  = 1'b1;
            hold_req = 1'b1;
         end
      end

      // Row length clamped from all ones; a long row cut off by a new image, then one left open
      settle();
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      set_geometry(3'd3, 15'h7fff);
      put_row(8'(pngu_pkg::FILT_SUB), 60, 1'b1);
      put_row(8'(pngu_pkg::FILT_PAETH), 30, 1'b1);

      // Drain and finish
      @(negedge clock);
      while (req_accepted != req_planned || pixel_due.size() != 0) @(negedge clock);
      repeat (2 * SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pixel_due.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
